// ===== rtl/core/i2rd_pkg.sv =====
// ----------------------------------------------------------------------------
// i2rd_pkg
// Shared constants, types and the digit-to-ASCII map for the radix converter.
// ----------------------------------------------------------------------------
package i2rd_pkg;

  localparam int VALUE_BITS = 31;
  localparam int MAX_DIGITS = 32;
  localparam int RADIX_BITS = 6;
  localparam int DIGIT_BITS = 6;
  localparam int CHAR_BITS  = 8;

  localparam int CNT_BITS  = $clog2(MAX_DIGITS + 1);
  localparam int IDX_BITS  = $clog2(MAX_DIGITS);
  localparam int BCNT_BITS = $clog2(VALUE_BITS);

  localparam logic [RADIX_BITS-1:0] RADIX_RESET = RADIX_BITS'(10);
  localparam logic [RADIX_BITS-1:0] RADIX_MIN   = RADIX_BITS'(2);
  localparam logic [RADIX_BITS-1:0] RADIX_MAX   = RADIX_BITS'(36);

  localparam logic [CHAR_BITS-1:0]  CHAR_ZERO   = 8'h30;  // '0'
  localparam logic [CHAR_BITS-1:0]  CHAR_UPPER_A = 8'h41; // 'A'
  localparam logic [CHAR_BITS-1:0]  CHAR_NINE   = 8'h39;  // '9'
  localparam logic [CHAR_BITS-1:0]  CHAR_UPPER_Z = 8'h5A; // 'Z'
  localparam logic [DIGIT_BITS-1:0] DIGIT_NINE  = DIGIT_BITS'(9);
  localparam logic [DIGIT_BITS-1:0] DIGIT_TEN   = DIGIT_BITS'(10);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_STORE,
    S_RD,
    S_LOAD,
    S_EMPTY
  } state_t;

  typedef struct packed {
    logic load;       // take in_value, clear digit count
    logic div_step;   // one restoring division step
    logic store;      // write remainder to digit store
    logic rd;         // read digit store at current index
    logic out_load;   // load output word
    logic out_empty;  // output word is the empty-result word
    logic idx_dec;    // step to next lower digit
  } cmd_t;

  typedef struct packed {
    logic q_zero;
    logic bit_done;
    logic idx_zero;
    logic out_free;
  } sts_t;

  function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [DIGIT_BITS-1:0] d);
    logic [CHAR_BITS-1:0] c;
    if (d <= DIGIT_NINE) begin
      c = CHAR_ZERO + CHAR_BITS'(d);
    end else begin
      c = CHAR_UPPER_A + CHAR_BITS'(d - DIGIT_TEN);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/i2rd_ram.sv =====
// ----------------------------------------------------------------------------
// i2rd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module i2rd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/i2rd_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2rd_ctrl
// Sequencer: divide loop per digit, then read-back and emission of digits, or the empty word for a zero value.
// ----------------------------------------------------------------------------
module i2rd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  i2rd_pkg::sts_t sts,
  output i2rd_pkg::cmd_t cmd,
  output i2rd_pkg::state_t state
);
  import i2rd_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_CHECK;
      S_CHECK: state_nxt = sts.q_zero ? S_EMPTY : S_DIV;
      S_DIV:   if (sts.bit_done) state_nxt = S_STORE;
      S_STORE: state_nxt = sts.q_zero ? S_RD : S_DIV;
      S_RD:    state_nxt = S_LOAD;
      S_LOAD: begin
        if (sts.out_free) begin
          state_nxt = sts.idx_zero ? S_IDLE : S_RD;
        end
      end
      S_EMPTY: if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_CHECK: ;
      S_DIV:   cmd.div_step = 1'b1;
      S_STORE: cmd.store = 1'b1;
      S_RD:    cmd.rd = 1'b1;
      S_LOAD: begin
        cmd.out_load = sts.out_free;
        cmd.idx_dec  = sts.out_free & ~sts.idx_zero;
      end
      S_EMPTY: begin
        cmd.out_load  = sts.out_free;
        cmd.out_empty = 1'b1;
      end
      default: ;
    endcase
  end

  assign state = state_r;

endmodule

// ===== rtl/core/i2rd_dp.sv =====
// ----------------------------------------------------------------------------
// i2rd_dp
// Datapath: radix register, bit-serial restoring divider, digit store and
// output word register.
// ----------------------------------------------------------------------------
module i2rd_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [i2rd_pkg::RADIX_BITS-1:0]     cfg_wr_data,
  input  logic [i2rd_pkg::VALUE_BITS-1:0]     in_value,
  input  i2rd_pkg::cmd_t                      cmd,
  output i2rd_pkg::sts_t                      sts,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [i2rd_pkg::CHAR_BITS-1:0]      out_digit_char,
  output logic                                out_last_digit,
  output logic                                out_empty_result
);
  import i2rd_pkg::*;

  logic [RADIX_BITS-1:0] radix_r;
  logic [RADIX_BITS-1:0] base;
  logic [VALUE_BITS-1:0] q_r, q_nxt;
  logic [DIGIT_BITS-1:0] rem_r, rem_nxt;
  logic [BCNT_BITS-1:0]  bit_cnt_r, bit_cnt_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [IDX_BITS-1:0]   idx_r, idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CHAR_BITS-1:0]  out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_empty_r, out_empty_nxt;

  logic [DIGIT_BITS:0]   trial;
  logic [DIGIT_BITS:0]   trial_diff;
  logic                  trial_ge;
  logic                  store_we;
  logic [DIGIT_BITS-1:0] rd_digit;

  always_comb begin
    if (radix_r < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = radix_r;
    end
  end

  // restoring step: shift next dividend bit into the partial remainder
  assign trial      = {rem_r, q_r[VALUE_BITS-1]};
  assign trial_ge   = trial >= {1'b0, base};
  assign trial_diff = trial - {1'b0, base};

  assign store_we = cmd.store & (cnt_r < CNT_BITS'(MAX_DIGITS));

  always_comb begin
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    bit_cnt_nxt   = bit_cnt_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;

    if (cmd.load) begin
      q_nxt       = in_value;
      rem_nxt     = '0;
      bit_cnt_nxt = '0;
      cnt_nxt     = '0;
    end
    if (cmd.div_step) begin
      q_nxt       = {q_r[VALUE_BITS-2:0], trial_ge};
      rem_nxt     = trial_ge ? trial_diff[DIGIT_BITS-1:0] : trial[DIGIT_BITS-1:0];
      bit_cnt_nxt = bit_cnt_r + BCNT_BITS'(1);
    end
    if (cmd.store) begin
      rem_nxt     = '0;
      bit_cnt_nxt = '0;
      if (store_we) begin
        cnt_nxt = cnt_r + CNT_BITS'(1);
        idx_nxt = cnt_r[IDX_BITS-1:0];
      end
    end
    if (cmd.idx_dec) begin
      idx_nxt = idx_r - IDX_BITS'(1);
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      if (cmd.out_empty) begin
        out_char_nxt  = '0;
        out_last_nxt  = 1'b1;
        out_empty_nxt = 1'b1;
      end else begin
        out_char_nxt  = digit_to_ascii(rd_digit);
        out_last_nxt  = (idx_r == '0);
        out_empty_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r     <= RADIX_RESET;
      bit_cnt_r   <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        radix_r <= cfg_wr_data;
      end
      bit_cnt_r   <= bit_cnt_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r         <= q_nxt;
    rem_r       <= rem_nxt;
    idx_r       <= idx_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
  end

  i2rd_ram #(
    .WIDTH (DIGIT_BITS),
    .DEPTH (MAX_DIGITS)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (cnt_r[IDX_BITS-1:0]),
    .wdata (rem_r),
    .re    (cmd.rd),
    .raddr (idx_r),
    .rdata (rd_digit)
  );

  assign sts.q_zero   = (q_r == '0);
  assign sts.bit_done = (bit_cnt_r == BCNT_BITS'(VALUE_BITS - 1));
  assign sts.idx_zero = (idx_r == '0);
  assign sts.out_free = ~out_valid_r | ~out_stall;

  assign out_valid        = out_valid_r;
  assign out_digit_char   = out_char_r;
  assign out_last_digit   = out_last_r;
  assign out_empty_result = out_empty_r;

endmodule

// ===== rtl/core/integer_to_radix_digits_unit.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_digits_unit
// Converts a non-negative integer to ASCII digits in base 2..36, most
// significant digit first, one output word per digit.
// ----------------------------------------------------------------------------
//   channel  dir  handshake             payload
//   in_      in   in_valid / in_stall   in_value[30:0]
//   out_     out  out_valid / out_stall out_digit_char[7:0], out_last_digit,
//                                       out_empty_result
//   cfg_     in   cfg_wr_en             cfg_wr_data[5:0] (radix)
//
// Each digit comes out of the bit-serial restoring divider into the digit
// store, least significant first; the emit phase reads the digits back and
// loads the output register, most significant first.
// One word is in flight at a time; the next word is accepted while the last
// digit of the previous one still waits in the output register.
// Output stall only holds the emit phase. Reset is synchronous, active low;
// radix resets to 10.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [i2rd_pkg::RADIX_BITS-1:0] cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [i2rd_pkg::VALUE_BITS-1:0] in_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [i2rd_pkg::CHAR_BITS-1:0]  out_digit_char,
  output logic                           out_last_digit,
  output logic                           out_empty_result
);
  import i2rd_pkg::*;

  cmd_t   cmd;
  sts_t   sts;
  state_t state;

  i2rd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  i2rd_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_value         (in_value),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_digit_char   (out_digit_char),
    .out_last_digit   (out_last_digit),
    .out_empty_result (out_empty_result)
  );

  // empty word is always a single, terminated, zero character
  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_result |-> out_last_digit && (out_digit_char == '0))
    else $error("empty word malformed");

  // digit words carry only '0'-'9' or 'A'-'Z'
  a_digit_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_empty_result |->
      ((out_digit_char >= CHAR_ZERO) && (out_digit_char <= CHAR_NINE)) ||
      ((out_digit_char >= CHAR_UPPER_A) && (out_digit_char <= CHAR_UPPER_Z)))
    else $error("digit character out of range");

  // block stays busy until the last digit has reached the output register
  a_busy_mid_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_digit |-> (state != S_IDLE) && in_stall)
    else $error("returned to idle before last digit");

  // an accepted word starts the conversion
  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> (state == S_CHECK))
    else $error("accepted word not started");

endmodule

// ===== bench/tb_integer_to_radix_digits_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_to_radix_digits_unit
// Self-checking bench for the radix digit converter. A directed table covers
// zero, single digits, the widest values and the clamped radix codes. Random
// values follow over a series of radix settings. Every output word is checked
// against a digit predictor, with random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_integer_to_radix_digits_unit;
  import i2rd_pkg::*;

  typedef struct packed {
    logic [CHAR_BITS-1:0] ch;
    logic                 last;
    logic                 empty;
  } digit_word_t;

  typedef struct {
    logic [VALUE_BITS-1:0] value;
    logic [RADIX_BITS-1:0] radix;
    bit                    typed;   // expected word typed in below
    logic [CHAR_BITS-1:0]  t_char;
    bit                    t_empty;
  } dir_row_t;

  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};
  localparam int N_PHASES    = 10;
  localparam int PHASE_ITEMS = 40;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [RADIX_BITS-1:0] cfg_wr_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [VALUE_BITS-1:0] in_value;
  logic                  out_valid;
  logic                  out_stall;
  logic [CHAR_BITS-1:0]  out_digit_char;
  logic                  out_last_digit;
  logic                  out_empty_result;

  digit_word_t           pending_words[$];
  logic [RADIX_BITS-1:0] radix_reg;
  int                    error_count;
  bit                    steady_mode;
  int                    stall_left;

  integer_to_radix_digits_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_digit_char   (out_digit_char),
    .out_last_digit   (out_last_digit),
    .out_empty_result (out_empty_result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Expected words for one value under the current radix, MSD first.
  function automatic void predict_digits(input logic [VALUE_BITS-1:0] v);
    logic [RADIX_BITS-1:0] base;
    logic [DIGIT_BITS-1:0] digs[MAX_DIGITS];
    logic [VALUE_BITS-1:0] rem;
    logic [DIGIT_BITS-1:0] d;
    digit_word_t           w;
    int                    n;
    base = radix_reg;
    if (radix_reg < RADIX_MIN) base = RADIX_MIN;
    if (radix_reg > RADIX_MAX) base = RADIX_MAX;
    rem = v;
    n = 0;
    while (rem != 0) begin
      if (n < MAX_DIGITS) begin
        digs[n] = DIGIT_BITS'(rem % VALUE_BITS'(base));
        n++;
      end
      rem = rem / VALUE_BITS'(base);
    end
    if (n == 0) begin
      w.ch = '0;
      w.last = 1'b1;
      w.empty = 1'b1;
      pending_words.push_back(w);
    end else begin
      for (int k = 0; k < n; k++) begin
        d = digs[n-1-k];
        if (d <= DIGIT_BITS'(9)) w.ch = CHAR_ZERO + CHAR_BITS'(d);
        else w.ch = CHAR_UPPER_A + CHAR_BITS'(d) - CHAR_BITS'(10);
        w.last = (k == n - 1);
        w.empty = 1'b0;
        pending_words.push_back(w);
      end
    end
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_mode || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_value();
    int unsigned sel;
    int unsigned k;
    logic [VALUE_BITS-1:0] one;
    sel = $urandom_range(0, 99);
    k = $urandom_range(0, VALUE_BITS - 1);
    one = VALUE_BITS'(1);
    if (sel < 8) return '0;
    if (sel < 35) return VALUE_BITS'($urandom_range(1, 255));
    if (sel < 55) return VALUE_BITS'($urandom) >> $urandom_range(0, VALUE_BITS - 1);
    if (sel < 85) return VALUE_BITS'($urandom);
    if (sel < 90) return one << k;
    if (sel < 95) return (one << k) - one;
    return VALUE_MAX;
  endfunction

  // Present one value; returns at the edge where it is taken.
  task automatic send_value(input logic [VALUE_BITS-1:0] v, input bit typed,
                            input digit_word_t typed_word);
    @(negedge clk);
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!(in_valid && !in_stall));
    if (typed) pending_words.push_back(typed_word);
    else predict_digits(v);
  endtask

  task automatic idle_gap(input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_words();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_radix(input logic [RADIX_BITS-1:0] r);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= r;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    radix_reg = r;
  endtask

  // Output stall: mostly short bursts, now and then a long hold.
  always @(negedge clk) begin : stall_gen
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_mode) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (r < 60) begin
      out_stall <= 1'b0;
    end else if (r < 92) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(10, 80);
    end
  end

  always @(posedge clk) begin : check_words
    digit_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        if (error_count < 10)
          $display("%0t: unexpected word char %h last %b empty %b", $realtime,
                   out_digit_char, out_last_digit, out_empty_result);
        error_count++;
      end else begin
        exp_w = pending_words.pop_front();
        if (exp_w.ch !== out_digit_char || exp_w.last !== out_last_digit ||
            exp_w.empty !== out_empty_result) begin
          if (error_count < 10)
            $display("%0t: expected char %h last %b empty %b, got char %h last %b empty %b",
                     $realtime, exp_w.ch, exp_w.last, exp_w.empty,
                     out_digit_char, out_last_digit, out_empty_result);
          error_count++;
        end
      end
    end
  end

  initial begin
    #200_000_000;
    $display("tb_integer_to_radix_digits_unit: FAIL");
    $finish;
  end

  initial begin : stimulus
    dir_row_t              rows[$];
    digit_word_t           tw;
    logic [RADIX_BITS-1:0] phase_radix[N_PHASES];
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_value = '0;
    out_stall = 1'b0;
    stall_left = 0;
    steady_mode = 1'b0;
    error_count = 0;
    radix_reg = RADIX_RESET;

    // value, radix, typed, char, empty
    rows.push_back('{31'd0,          6'd10, 1, 8'h00, 1});
    rows.push_back('{31'd1,          6'd10, 1, "1",   0});
    rows.push_back('{31'd9,          6'd10, 1, "9",   0});
    rows.push_back('{31'd10,         6'd10, 0, 8'h00, 0});
    rows.push_back('{VALUE_MAX,      6'd10, 0, 8'h00, 0});
    rows.push_back('{VALUE_MAX,      6'd2,  0, 8'h00, 0});
    rows.push_back('{31'd1,          6'd2,  1, "1",   0});
    rows.push_back('{31'd0,          6'd2,  1, 8'h00, 1});
    rows.push_back('{31'h4000_0000,  6'd2,  0, 8'h00, 0});
    rows.push_back('{31'd35,         6'd36, 1, "Z",   0});
    rows.push_back('{31'd10,         6'd36, 1, "A",   0});
    rows.push_back('{31'd36,         6'd36, 0, 8'h00, 0});
    rows.push_back('{VALUE_MAX,      6'd36, 0, 8'h00, 0});
    rows.push_back('{31'd5,          6'd0,  0, 8'h00, 0});   // clamps to base 2
    rows.push_back('{31'd5,          6'd1,  0, 8'h00, 0});
    rows.push_back('{31'd0,          6'd1,  1, 8'h00, 1});
    rows.push_back('{31'd100,        6'd63, 0, 8'h00, 0});   // clamps to base 36
    rows.push_back('{31'd35,         6'd37, 1, "Z",   0});
    rows.push_back('{VALUE_MAX,      6'd3,  0, 8'h00, 0});
    rows.push_back('{31'd15,         6'd16, 1, "F",   0});
    rows.push_back('{31'd255,        6'd16, 0, 8'h00, 0});
    rows.push_back('{31'h5555_5555,  6'd4,  0, 8'h00, 0});
    rows.push_back('{31'h2AAA_AAAA,  6'd7,  0, 8'h00, 0});

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    foreach (rows[i]) begin
      if (rows[i].radix != radix_reg) begin
        drain_words();
        write_radix(rows[i].radix);
      end
      tw.ch = rows[i].t_char;
      tw.last = 1'b1;
      tw.empty = rows[i].t_empty;
      send_value(rows[i].value, rows[i].typed, tw);
      idle_gap(pick_gap());
    end

    phase_radix = '{6'd10, 6'd2, 6'd36, 6'd0, 6'd63, 6'd1, 6'd37, 6'd16, 6'd8, 6'd23};
    for (int p = 0; p < N_PHASES; p++) begin
      drain_words();
      if (p >= N_PHASES - 2) write_radix(RADIX_BITS'($urandom_range(0, 63)));
      else write_radix(phase_radix[p]);
      steady_mode = (p == 0) || ($urandom_range(0, 3) == 0);
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        send_value(pick_value(), 1'b0, tw);
        // hold off now and then until the converter has emptied
        if ($urandom_range(0, 49) == 0) drain_words();
        else idle_gap(pick_gap());
      end
    end
    steady_mode = 1'b0;

    drain_words();
    repeat (50) @(posedge clk);
    if (pending_words.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("tb_integer_to_radix_digits_unit: PASS");
    end else begin
      $display("tb_integer_to_radix_digits_unit: FAIL");
    end
    $finish;
  end

endmodule
